// File: rtl/adm_pkg.sv
// shared types, constants and codes of the adam parameter update core
`default_nettype none
package adm_pkg;

	localparam int MAX_LAYERS = 64;
	localparam int LAYER_AW = $clog2(MAX_LAYERS);
	localparam int Q_DEPTH = 2;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int MATH_CW = 7;

	localparam logic [31:0] B1_Q32 = 32'd3865470566;
	localparam logic [31:0] C1_Q32 = 32'd429496730;
	localparam logic [31:0] B2_Q32 = 32'd4290672329;
	localparam logic [31:0] C2_Q32 = 32'd4294967;
	localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

	localparam logic [31:0] LR_RESET = 32'd167772;
	localparam logic [30:0] TOL_RESET = 31'd66;
	localparam logic [15:0] MAXIT_RESET = 16'd1000;
	localparam logic [6:0] LAYERS_RESET = 7'd1;

	localparam logic CMD_START = 1'b0;

	typedef enum logic [1:0] {
		ST_RUN = 2'd0,
		ST_CONV = 2'd1,
		ST_LIMIT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_CLEAR,
		K_PASS,
		K_UPD
	} kind_t;

	typedef enum logic [2:0] {
		REG_LR = 3'd0,
		REG_TOL = 3'd1,
		REG_MAXIT = 3'd2,
		REG_LAYERS = 3'd3,
		REG_CHECK = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_SQRT,
		OP_DIV
	} math_op_t;

	typedef struct packed {
		logic start;
		math_op_t op;
	} math_req_t;

	typedef struct packed {
		kind_t kind;
		logic [5:0] layer;
		logic signed [31:0] grad_beta;
		logic signed [31:0] grad_gamma;
		logic signed [31:0] beta;
		logic signed [31:0] gamma;
		logic [31:0] b1p;
		logic [31:0] b2p;
		status_t status;
		logic [15:0] iter;
	} q_entry_t;

endpackage
`default_nettype wire

// File: rtl/adm_front.sv
// front end: accepts items, keeps iteration control state, classifies items
`default_nettype none
module adm_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic cmd,
	input wire logic [5:0] layer,
	input wire logic signed [31:0] grad_beta,
	input wire logic signed [31:0] grad_gamma,
	input wire logic signed [31:0] beta_in,
	input wire logic signed [31:0] gamma_in,
	input wire logic signed [31:0] objective,
	input wire logic [30:0] tolerance,
	input wire logic [15:0] max_iterations,
	input wire logic [6:0] layers_in_use,
	input wire logic check_first,
	input wire logic q_full,
	output logic push,
	output adm_pkg::q_entry_t push_entry
);
	import adm_pkg::*;

	logic [15:0] step_q;
	logic [31:0] b1p_q, b2p_q;
	logic signed [31:0] prev_q;
	logic have_prev_q, pend_q, halted_q;

	logic [6:0] active;
	logic in_range, is_first, is_last;
	logic signed [32:0] dobj;
	logic [32:0] diff;
	logic conv, at_limit;
	logic [63:0] pw1, pw2;
	logic [15:0] step_n;
	logic [31:0] b1p_n, b2p_n;
	logic pend_n, halted_n, advance;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	assign active = (layers_in_use > 7'(MAX_LAYERS)) ? 7'(MAX_LAYERS) : layers_in_use;
	assign in_range = {1'b0, layer} < active;
	assign is_first = (layer == 6'd0);
	assign is_last = ({1'b0, layer} == active - 7'd1);

	assign dobj = {prev_q[31], prev_q} - {objective[31], objective};
	assign diff = dobj[32] ? 33'(-dobj) : 33'(dobj);
	assign conv = have_prev_q && (check_first ? (diff < {2'b0, tolerance})
		: (diff <= {2'b0, tolerance}));
	assign at_limit = step_q >= max_iterations;

	assign pw1 = 64'(b1p_q) * 64'(B1_Q32) + 64'h8000_0000;
	assign pw2 = 64'(b2p_q) * 64'(B2_Q32) + 64'h8000_0000;

	always_comb begin
		advance = 1'b0;
		halted_n = halted_q;
		pend_n = pend_q;
		if (in_range && is_first) begin
			if (at_limit) begin
				halted_n = 1'b1;
				pend_n = 1'b0;
			end else if (check_first && conv) begin
				halted_n = 1'b1;
				pend_n = 1'b1;
			end else begin
				halted_n = 1'b0;
				pend_n = check_first ? 1'b0 : conv;
				advance = 1'b1;
			end
		end
		step_n = advance ? step_q + 16'd1 : step_q;
		b1p_n = advance ? pw1[63:32] : b1p_q;
		b2p_n = advance ? pw2[63:32] : b2p_q;
	end

	always_comb begin
		push_entry.layer = layer;
		push_entry.grad_beta = grad_beta;
		push_entry.grad_gamma = grad_gamma;
		push_entry.beta = beta_in;
		push_entry.gamma = gamma_in;
		push_entry.b1p = b1p_n;
		push_entry.b2p = b2p_n;
		push_entry.status = ST_RUN;
		push_entry.iter = step_n;
		if (cmd == CMD_START) begin
			push_entry.kind = K_CLEAR;
			push_entry.iter = 16'd0;
		end else if (!in_range) begin
			push_entry.kind = K_PASS;
		end else begin
			push_entry.kind = halted_n ? K_PASS : K_UPD;
			if (is_last) begin
				if (halted_n) begin
					push_entry.status = pend_n ? ST_CONV : ST_LIMIT;
				end else if (step_n >= max_iterations) begin
					push_entry.status = ST_LIMIT;
				end else if (pend_n) begin
					push_entry.status = ST_CONV;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			b1p_q <= MASK32;
			b2p_q <= MASK32;
			prev_q <= '0;
			have_prev_q <= 1'b0;
			pend_q <= 1'b0;
			halted_q <= 1'b0;
		end else if (push) begin
			if (cmd == CMD_START) begin
				step_q <= '0;
				b1p_q <= MASK32;
				b2p_q <= MASK32;
				prev_q <= '0;
				have_prev_q <= 1'b0;
				pend_q <= 1'b0;
				halted_q <= 1'b0;
			end else if (in_range && is_first) begin
				halted_q <= halted_n;
				pend_q <= pend_n;
				step_q <= step_n;
				b1p_q <= b1p_n;
				b2p_q <= b2p_n;
				if (advance) begin
					prev_q <= objective;
					have_prev_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/adm_fifo.sv
// short item queue between front end and back end
`default_nettype none
module adm_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire adm_pkg::q_entry_t push_entry,
	output logic full,
	input wire logic pop,
	output adm_pkg::q_entry_t head,
	output logic head_valid
);
	import adm_pkg::*;

	q_entry_t buf_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0] cnt_q;

	assign full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// File: rtl/adm_seqmath.sv
// shared iterative unit: 64-bit integer square root or 64 by 33 bit division
`default_nettype none
module adm_seqmath (
	input wire logic clk,
	input wire logic arst_n,
	input wire adm_pkg::math_req_t req,
	input wire logic [63:0] a,
	input wire logic [32:0] b,
	output logic done,
	output logic [63:0] res
);
	import adm_pkg::*;

	logic busy_q, done_q;
	math_op_t op_q;
	logic [MATH_CW-1:0] cnt_q;
	logic [63:0] x_q, r_q, bit_q;
	logic [32:0] rem_q, b_q;

	logic [63:0] sq_t;
	logic [33:0] rs;
	logic ge;

	assign done = done_q;
	assign res = r_q;
	assign sq_t = r_q + bit_q;
	assign rs = {rem_q, x_q[63]};
	assign ge = rs >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= OP_SQRT;
			cnt_q <= '0;
			x_q <= '0;
			r_q <= '0;
			bit_q <= '0;
			rem_q <= '0;
			b_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				x_q <= a;
				r_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
				rem_q <= '0;
				b_q <= b;
				cnt_q <= (req.op == OP_SQRT) ? MATH_CW'(32) : MATH_CW'(64);
			end else if (busy_q) begin
				if (op_q == OP_SQRT) begin
					if (x_q >= sq_t) begin
						x_q <= x_q - sq_t;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					rem_q <= ge ? 33'(rs - {1'b0, b_q}) : rs[32:0];
					r_q <= {r_q[62:0], ge};
					x_q <= {x_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MATH_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/adm_back.sv
// back end: moment memory, bias-corrected rate and per-parameter adam step
`default_nettype none
module adm_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [31:0] learn_rate,
	input wire adm_pkg::q_entry_t head,
	input wire logic head_valid,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] beta_out,
	output logic signed [31:0] gamma_out,
	output logic [1:0] status,
	output logic [15:0] iteration_count
);
	import adm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_RSQ_GO, S_RSQ_W, S_RMUL, S_RDIV_GO, S_RDIV_W,
		S_M1, S_M2, S_M3, S_G4, S_V2, S_V3, S_V4, S_V5,
		S_PSQ_GO, S_PSQ_W, S_PMUL, S_PDIV_GO, S_PDIV_W, S_PFIN, S_DONE
	} state_t;

	typedef struct packed {
		logic signed [31:0] bm;
		logic [47:0] bv;
		logic signed [31:0] gm;
		logic [47:0] gv;
	} mom_t;

	mom_t mem [MAX_LAYERS];
	logic [MAX_LAYERS-1:0] vld_q;

	state_t state_q;
	q_entry_t e_q;
	mom_t mom_q, nmom_q;
	logic mvld_q, p_q;
	logic signed [65:0] prod_q, acc_q;
	logic [31:0] s_q, rate_q, mn_q;
	logic [46:0] g2_q;
	logic [49:0] vacc_q;
	logic [47:0] vn_q;
	logic [32:0] den_q;
	logic [63:0] q_q;
	logic signed [31:0] res_b_q, res_g_q;
	logic out_valid_q;
	logic signed [31:0] beta_out_q, gamma_out_q;
	logic [1:0] status_q;
	logic [15:0] iter_q;

	math_req_t mreq;
	logic [63:0] ma;
	logic [32:0] mb;
	logic mdone;
	logic [63:0] mres;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic signed [31:0] cur_m, cur_g, cur_par;
	logic [47:0] cur_v;
	logic [31:0] gabs, mabs, d2c;
	logic signed [65:0] msum, mrnd;
	logic [63:0] g2r;
	logic [64:0] rnd;
	logic [63:0] dq;
	logic [56:0] delta;
	logic signed [65:0] nsum;
	logic signed [31:0] nsat;
	logic out_free, mem_we;

	assign out_free = !out_valid_q || !out_stall;
	assign pop = (state_q == S_IDLE) && head_valid;
	assign mem_we = (state_q == S_DONE) && out_free && (e_q.kind == K_UPD);

	assign out_valid = out_valid_q;
	assign beta_out = beta_out_q;
	assign gamma_out = gamma_out_q;
	assign status = status_q;
	assign iteration_count = iter_q;

	adm_seqmath u_math (
		.clk (clk),
		.arst_n (arst_n),
		.req (mreq),
		.a (ma),
		.b (mb),
		.done (mdone),
		.res (mres)
	);

	assign cur_m = !mvld_q ? 32'sd0 : (p_q ? mom_q.gm : mom_q.bm);
	assign cur_v = !mvld_q ? 48'd0 : (p_q ? mom_q.gv : mom_q.bv);
	assign cur_g = p_q ? e_q.grad_gamma : e_q.grad_beta;
	assign cur_par = p_q ? e_q.gamma : e_q.beta;
	assign gabs = cur_g[31] ? 32'(-cur_g) : 32'(cur_g);
	assign mabs = mn_q[31] ? 32'(-$signed(mn_q)) : mn_q;
	assign d2c = (e_q.b2p == 32'd0) ? MASK32 : 32'(-e_q.b2p);

	always_comb begin
		mreq.start = 1'b0;
		mreq.op = OP_SQRT;
		ma = '0;
		mb = '0;
		case (state_q)
			S_RSQ_GO: begin
				mreq.start = 1'b1;
				ma = {d2c, 32'd0};
			end
			S_RDIV_GO: begin
				mreq.start = 1'b1;
				mreq.op = OP_DIV;
				ma = prod_q[63:0];
				mb = 33'h1_0000_0000 - {1'b0, e_q.b1p};
			end
			S_PSQ_GO: begin
				mreq.start = 1'b1;
				ma = {vn_q, 16'd0};
			end
			S_PDIV_GO: begin
				mreq.start = 1'b1;
				mreq.op = OP_DIV;
				ma = prod_q[63:0];
				mb = den_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_RMUL: begin
				mul_a = {2'b0, learn_rate};
				mul_b = {2'b0, s_q};
			end
			S_M1: begin
				mul_a = 34'(cur_m);
				mul_b = {2'b0, B1_Q32};
			end
			S_M2: begin
				mul_a = 34'(cur_g);
				mul_b = {2'b0, C1_Q32};
			end
			S_M3: begin
				mul_a = {2'b0, gabs};
				mul_b = {2'b0, gabs};
			end
			S_G4: begin
				mul_a = {18'b0, cur_v[47:32]};
				mul_b = {2'b0, B2_Q32};
			end
			S_V2: begin
				mul_a = {2'b0, cur_v[31:0]};
				mul_b = {2'b0, B2_Q32};
			end
			S_V3: begin
				mul_a = {19'b0, g2_q[46:32]};
				mul_b = {2'b0, C2_Q32};
			end
			S_V4: begin
				mul_a = {2'b0, g2_q[31:0]};
				mul_b = {2'b0, C2_Q32};
			end
			S_PMUL: begin
				mul_a = {2'b0, rate_q};
				mul_b = {2'b0, mabs};
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign msum = acc_q + prod_q;
	assign mrnd = msum + 66'sh8000_0000;
	assign g2r = prod_q[63:0] + 64'h8000;
	assign rnd = {1'b0, prod_q[63:0]} + 65'h8000_0000;
	assign dq = q_q + 64'd128;
	assign delta = dq[63:8] == 56'd0 ? 57'd0 : {1'b0, dq[63:8]};
	assign nsum = mn_q[31] ? 66'(cur_par) + 66'(delta) : 66'(cur_par) - 66'(delta);
	assign nsat = (nsum > 66'sd2147483647) ? 32'sh7FFF_FFFF
		: (nsum < -66'sd2147483648) ? 32'sh8000_0000 : nsum[31:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			mom_q <= mem[head.layer[LAYER_AW-1:0]];
		end
		if (mem_we) begin
			mem[e_q.layer[LAYER_AW-1:0]] <= nmom_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			e_q <= '0;
			nmom_q <= '0;
			mvld_q <= 1'b0;
			p_q <= 1'b0;
			prod_q <= '0;
			acc_q <= '0;
			s_q <= '0;
			rate_q <= '0;
			mn_q <= '0;
			g2_q <= '0;
			vacc_q <= '0;
			vn_q <= '0;
			den_q <= '0;
			q_q <= '0;
			res_b_q <= '0;
			res_g_q <= '0;
			out_valid_q <= 1'b0;
			beta_out_q <= '0;
			gamma_out_q <= '0;
			status_q <= '0;
			iter_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			prod_q <= mul_p[65:0];
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						e_q <= head;
						mvld_q <= vld_q[head.layer[LAYER_AW-1:0]];
						res_b_q <= head.beta;
						res_g_q <= head.gamma;
						p_q <= 1'b0;
						state_q <= (head.kind == K_UPD) ? S_RSQ_GO : S_DONE;
					end
				end
				S_RSQ_GO: state_q <= S_RSQ_W;
				S_RSQ_W: begin
					if (mdone) begin
						s_q <= mres[31:0];
						state_q <= S_RMUL;
					end
				end
				S_RMUL: state_q <= S_RDIV_GO;
				S_RDIV_GO: state_q <= S_RDIV_W;
				S_RDIV_W: begin
					if (mdone) begin
						rate_q <= (mres[63:32] != 32'd0) ? MASK32 : mres[31:0];
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					acc_q <= prod_q;
					state_q <= S_M3;
				end
				S_M3: begin
					mn_q <= mrnd[63:32];
					state_q <= S_G4;
				end
				S_G4: begin
					g2_q <= g2r[62:16];
					state_q <= S_V2;
				end
				S_V2: begin
					vacc_q <= prod_q[49:0];
					state_q <= S_V3;
				end
				S_V3: begin
					vacc_q <= vacc_q + 50'(rnd[64:32]);
					state_q <= S_V4;
				end
				S_V4: begin
					vacc_q <= vacc_q + prod_q[49:0];
					state_q <= S_V5;
				end
				S_V5: begin
					vn_q <= 48'(vacc_q + 50'(rnd[64:32]));
					state_q <= S_PSQ_GO;
				end
				S_PSQ_GO: state_q <= S_PSQ_W;
				S_PSQ_W: begin
					if (mdone) begin
						den_q <= mres[32:0] + 33'd1;
						state_q <= S_PMUL;
					end
				end
				S_PMUL: state_q <= S_PDIV_GO;
				S_PDIV_GO: state_q <= S_PDIV_W;
				S_PDIV_W: begin
					if (mdone) begin
						q_q <= mres;
						state_q <= S_PFIN;
					end
				end
				S_PFIN: begin
					if (p_q) begin
						res_g_q <= nsat;
						nmom_q.gm <= mn_q;
						nmom_q.gv <= vn_q;
						state_q <= S_DONE;
					end else begin
						res_b_q <= nsat;
						nmom_q.bm <= mn_q;
						nmom_q.bv <= vn_q;
						p_q <= 1'b1;
						state_q <= S_M1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						beta_out_q <= res_b_q;
						gamma_out_q <= res_g_q;
						status_q <= e_q.status;
						iter_q <= e_q.iter;
						if (e_q.kind == K_CLEAR) begin
							vld_q <= '0;
						end else if (e_q.kind == K_UPD) begin
							vld_q[e_q.layer[LAYER_AW-1:0]] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> (state_q == S_RSQ_W || state_q == S_RDIV_W
		|| state_q == S_PSQ_W || state_q == S_PDIV_W))
		else $error("math result arrived outside a wait state");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside done state");
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != S_IDLE)
		else $error("item popped but back end stayed idle");
	a_write_upd: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> out_valid_q)
		else $error("moments written without a result");
`endif

endmodule
`default_nettype wire

// File: rtl/adam_parameter_update_core.sv
// top level of the adam parameter update core with configuration registers
//
// channel  | handshake           | payload
// input    | in_valid / in_stall | cmd, layer, grad_beta, grad_gamma, beta_in, gamma_in, objective
// output   | out_valid/out_stall | beta_out, gamma_out, status, iteration_count
// config   | cfg_we              | cfg_index, cfg_wdata
//
// an update item runs three square roots and three divisions
// one bit step a cycle in the shared iterative unit
// start and out-of-range or halted items skip the arithmetic and go straight to the result
// the front end takes items into a two-entry queue while the back end works
// arst_n clears all control state and the moment valid bits
`default_nettype none
module adam_parameter_update_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic cmd,
	input wire logic [5:0] layer,
	input wire logic signed [31:0] grad_beta,
	input wire logic signed [31:0] grad_gamma,
	input wire logic signed [31:0] beta_in,
	input wire logic signed [31:0] gamma_in,
	input wire logic signed [31:0] objective,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] beta_out,
	output logic signed [31:0] gamma_out,
	output logic [1:0] status,
	output logic [15:0] iteration_count
);
	import adm_pkg::*;

	logic [31:0] lr_q;
	logic [30:0] tol_q;
	logic [15:0] maxit_q;
	logic [6:0] layers_q;
	logic check_q;

	logic push, q_full, pop, head_valid;
	q_entry_t push_entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
			tol_q <= TOL_RESET;
			maxit_q <= MAXIT_RESET;
			layers_q <= LAYERS_RESET;
			check_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LR: lr_q <= cfg_wdata;
				REG_TOL: tol_q <= cfg_wdata[30:0];
				REG_MAXIT: maxit_q <= cfg_wdata[15:0];
				REG_LAYERS: layers_q <= cfg_wdata[6:0];
				REG_CHECK: check_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	adm_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd (cmd),
		.layer (layer),
		.grad_beta (grad_beta),
		.grad_gamma (grad_gamma),
		.beta_in (beta_in),
		.gamma_in (gamma_in),
		.objective (objective),
		.tolerance (tol_q),
		.max_iterations (maxit_q),
		.layers_in_use (layers_q),
		.check_first (check_q),
		.q_full (q_full),
		.push (push),
		.push_entry (push_entry)
	);

	adm_fifo u_fifo (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.push_entry (push_entry),
		.full (q_full),
		.pop (pop),
		.head (head),
		.head_valid (head_valid)
	);

	adm_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.learn_rate (lr_q),
		.head (head),
		.head_valid (head_valid),
		.pop (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.beta_out (beta_out),
		.gamma_out (gamma_out),
		.status (status),
		.iteration_count (iteration_count)
	);

endmodule
`default_nettype wire
